### hdl/smaf_pkg.sv
// Package for the speed moving-average filter: field widths, default sizes,
// command codes and the control struct between the top level and the accumulator.
// No dependencies.
package smaf_pkg;

   localparam int SPEED_W             = 32;
   localparam int WREQ_W              = 3;
   localparam int RING_DEPTH_DEF      = 16;
   localparam int MAX_WINDOW_BITS_DEF = 4;

   typedef enum logic [0:0] {
      CMD_SAMPLE = 1'b0,
      CMD_WINDOW = 1'b1
   } cmd_type;

   // One executed beat, as seen by the accumulator.
   typedef struct packed {
      logic              sample_en;
      logic              window_en;
      logic [WREQ_W-1:0] window_request;
      logic [WREQ_W-1:0] default_bits;
   } accum_ctrl_type;

endpackage

### hdl/smaf_req_if.sv
// Request channel of the speed moving-average filter: valid/ready plus the command beat.
// Depends on smaf_pkg.
interface smaf_req_if import smaf_pkg::*;;

   logic                      valid;
   logic                      ready;
   cmd_type                   cmd;
   logic signed [SPEED_W-1:0] speed;
   logic [WREQ_W-1:0]         window_request;

   modport source (output valid, cmd, speed, window_request, input ready);
   modport sink   (input valid, cmd, speed, window_request, output ready);

endinterface

### hdl/smaf_rsp_if.sv
// Response channel of the speed moving-average filter: valid/ready plus the filtered speed.
// Depends on smaf_pkg.
interface smaf_rsp_if import smaf_pkg::*;;

   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] filtered_speed;

   modport source (output valid, filtered_speed, input ready);
   modport sink   (input valid, filtered_speed, output ready);

endinterface

### hdl/smaf_ring.sv
// Sample ring: one write port, one read port with registered read data.
// Depends on smaf_pkg.
module smaf_ring import smaf_pkg::*; #(
   parameter int DEPTH = RING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic signed [SPEED_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic signed [SPEED_W-1:0]        rd_data
);

   logic signed [SPEED_W-1:0] mem_ff [DEPTH];
   logic signed [SPEED_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/smaf_accum.sv
// Window state, running sum and result for the moving-average filter.
// Depends on smaf_pkg and smaf_ring.
module smaf_accum import smaf_pkg::*; #(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int MAX_WINDOW_BITS = MAX_WINDOW_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  accum_ctrl_type            ctrl,
   input  logic signed [SPEED_W-1:0] speed,
   output logic signed [SPEED_W-1:0] filtered_speed
);

   localparam int KW     = $clog2(MAX_WINDOW_BITS + 1);
   localparam int IDX_W  = $clog2(RING_DEPTH + 1);
   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int SUM_W  = SPEED_W + MAX_WINDOW_BITS;
   localparam int CW     = (IDX_W > MAX_WINDOW_BITS + 1) ? IDX_W : MAX_WINDOW_BITS + 1;

   logic [KW-1:0]           k_ff, k_in, new_k;
   logic [IDX_W-1:0]        idx_ff, idx_in, idx_inc;
   logic                    filled_ff, filled_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_upd, old_sample, shifted;
   logic [ADDR_W-1:0]       cur_addr, pre_addr;
   logic                    window_hit;
   logic                    ring_wr;
   logic signed [SPEED_W-1:0] ring_rd;

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] a;
      if (idx >= IDX_W'(RING_DEPTH)) begin
         a = '0;
      end else begin
         a = idx[ADDR_W-1:0];
      end
      return a;
   endfunction

   // requested exponent, falling back on the default register, saturated
   always_comb begin
      if (32'(ctrl.window_request) <= 32'(MAX_WINDOW_BITS)) begin
         new_k = KW'(ctrl.window_request);
      end else if (32'(ctrl.default_bits) <= 32'(MAX_WINDOW_BITS)) begin
         new_k = KW'(ctrl.default_bits);
      end else begin
         new_k = KW'(MAX_WINDOW_BITS);
      end
   end

   assign cur_addr   = ring_addr(idx_ff);
   assign idx_inc    = IDX_W'(cur_addr) + IDX_W'(1);
   assign window_hit = CW'(idx_inc) >= (CW'(1) << k_ff);
   assign old_sample = filled_ff ? SUM_W'(ring_rd) : '0;
   assign sum_upd    = sum_ff - old_sample + SUM_W'(speed);
   assign ring_wr    = ctrl.sample_en && (k_ff != '0);

   always_comb begin
      k_in      = k_ff;
      idx_in    = idx_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      if (ctrl.window_en && (new_k != k_ff)) begin
         k_in      = new_k;
         idx_in    = '0;
         filled_in = 1'b0;
         sum_in    = '0;
      end else if (ring_wr) begin
         idx_in    = window_hit ? '0 : idx_inc;
         filled_in = filled_ff | window_hit;
         sum_in    = sum_upd;
      end
   end

   // prefetch the entry the next sample will overwrite
   assign pre_addr = ring_addr(idx_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= '0;
         idx_ff    <= '0;
         filled_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         k_ff      <= k_in;
         idx_ff    <= idx_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
      end
   end

   smaf_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (cur_addr),
      .wr_data (speed),
      .rd_addr (pre_addr),
      .rd_data (ring_rd)
   );

   assign shifted        = sum_upd >>> k_ff;
   assign filtered_speed = (k_ff == '0) ? speed : shifted[SPEED_W-1:0];

`ifndef SYNTHESIS
   a_passthru_clear: assert property (@(posedge clock) disable iff (reset)
      (k_ff == '0) |-> (!filled_ff && (sum_ff == '0)))
      else $error("pass-through window carries fill state");
   a_idx_in_window: assert property (@(posedge clock) disable iff (reset)
      (k_ff != '0) |-> (CW'(idx_ff) < (CW'(1) << k_ff)))
      else $error("ring index beyond window");
   a_fill_at_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(filled_ff) |-> (idx_ff == '0))
      else $error("fill flag set without index wrap");
`endif

endmodule

### hdl/speed_moving_average_filter_core.sv
// Speed moving-average filter: input register, accumulator, output register.
// A sample beat moves from the input register through the accumulator into the output register.
// One beat per cycle, limited by the ring read/add/subtract path, unless a sample waits on a stalled output register.
// Reset (synchronous, active high) clears handshake state, index, fill flag, sum,
// window exponent (pass-through) and default register; ring contents stay undefined.
// Depends on smaf_pkg, smaf_req_if, smaf_rsp_if, smaf_accum.
module speed_moving_average_filter_core import smaf_pkg::*; #(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int MAX_WINDOW_BITS = MAX_WINDOW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   smaf_req_if.sink          req,
   smaf_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [WREQ_W-1:0] csr_write_data
);

   // input register stage
   logic                      s1_valid_ff, s1_valid_in;
   cmd_type                   s1_cmd_ff;
   logic signed [SPEED_W-1:0] s1_speed_ff;
   logic [WREQ_W-1:0]         s1_wreq_ff;

   // output register stage
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_data_ff;

   logic [WREQ_W-1:0]         csr_default_ff;

   logic                      out_free;
   logic                      exec_beat;
   logic                      exec_sample;
   logic                      accept;
   accum_ctrl_type            ctrl;
   logic signed [SPEED_W-1:0] result;

   // A window beat never needs the output register; a sample beat needs it
   // empty or draining this cycle.
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign exec_beat   = s1_valid_ff && ((s1_cmd_ff == CMD_WINDOW) || out_free);
   assign exec_sample = exec_beat && (s1_cmd_ff == CMD_SAMPLE);

   // take a new beat whenever the input register is empty or moving on
   assign req.ready = !s1_valid_ff || exec_beat;
   assign accept    = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (exec_beat) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_sample) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         csr_default_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            csr_default_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req.cmd;
         s1_speed_ff <= req.speed;
         s1_wreq_ff  <= req.window_request;
      end
      if (exec_sample) begin
         rsp_data_ff <= result;
      end
   end

   always_comb begin
      ctrl.sample_en      = exec_sample;
      ctrl.window_en      = exec_beat && (s1_cmd_ff == CMD_WINDOW);
      ctrl.window_request = s1_wreq_ff;
      ctrl.default_bits   = csr_default_ff;
   end

   smaf_accum #(
      .RING_DEPTH      (RING_DEPTH),
      .MAX_WINDOW_BITS (MAX_WINDOW_BITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .speed          (s1_speed_ff),
      .filtered_speed (result)
   );

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.filtered_speed = rsp_data_ff;

`ifndef SYNTHESIS
   a_sample_to_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_sample |=> rsp.valid)
      else $error("executed sample beat produced no response");
   a_window_no_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_cmd_ff == CMD_WINDOW)) |-> exec_beat)
      else $error("window beat stalled in input register");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.filtered_speed)))
      else $error("response beat changed while stalled");
`endif

endmodule

### bench/filtered_speed_checker.sv
// Checker for the speed moving-average filter: tracks window, ring and sum from the
// accepted request beats and compares every response beat with its prediction.
// Depends on smaf_pkg, smaf_req_if and smaf_rsp_if.
module filtered_speed_checker import smaf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   smaf_req_if               req,
   smaf_rsp_if               rsp,
   input  logic              csr_write_enable,
   input  logic [WREQ_W-1:0] csr_write_data,
   output int                pending_count,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_W = SPEED_W + MAX_WINDOW_BITS_DEF;
   localparam int IDX_W = $clog2(RING_DEPTH_DEF);

   logic signed [SPEED_W-1:0] ring [RING_DEPTH_DEF];
   logic signed [SUM_W-1:0]   sum;
   logic [IDX_W-1:0]          idx;
   logic                      filled;
   logic [WREQ_W-1:0]         win_bits;
   logic [WREQ_W-1:0]         default_bits;

   logic signed [SPEED_W-1:0] expected_speeds [$];
   int                        fails;

   function automatic logic signed [SPEED_W-1:0] filter_sample(
      input logic signed [SPEED_W-1:0] sample);
      int                      next_idx;
      logic signed [SUM_W-1:0] evicted;
      logic signed [SUM_W-1:0] shifted;
      if (win_bits == '0) begin
         return sample;
      end
      evicted = '0;
      if (filled) begin
         evicted = SUM_W'(ring[idx]);
      end
      ring[idx] = sample;
      next_idx = int'(idx) + 1;
      if (next_idx >= (1 << win_bits)) begin
         next_idx = 0;
         filled = 1'b1;
      end
      idx = IDX_W'(next_idx);
      sum = sum - evicted + SUM_W'(sample);
      shifted = sum >>> win_bits;
      return shifted[SPEED_W-1:0];
   endfunction

   function automatic void select_window(input logic [WREQ_W-1:0] request);
      logic [WREQ_W-1:0] k;
      if (int'(request) <= MAX_WINDOW_BITS_DEF) begin
         k = request;
      end else if (int'(default_bits) <= MAX_WINDOW_BITS_DEF) begin
         k = default_bits;
      end else begin
         k = WREQ_W'(MAX_WINDOW_BITS_DEF);
      end
      if (k != win_bits) begin
         win_bits = k;
         idx = '0;
         filled = 1'b0;
         sum = '0;
      end
   endfunction

   always @(posedge clock) begin
      logic signed [SPEED_W-1:0] want;
      if (reset) begin
         sum = '0;
         idx = '0;
         filled = 1'b0;
         win_bits = '0;
         default_bits = '0;
         expected_speeds.delete();
         fails = 0;
      end else begin
         if (csr_write_enable) begin
            default_bits = csr_write_data;
         end
         if (req.valid && req.ready) begin
            if (req.cmd == CMD_WINDOW) begin
               select_window(req.window_request);
            end else begin
               expected_speeds.push_back(filter_sample(req.speed));
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_speeds.size() == 0) begin
               $error("filtered_speed: unexpected beat, actual %0d", rsp.filtered_speed);
               fails++;
            end else begin
               want = expected_speeds.pop_front();
               if (rsp.filtered_speed !== want) begin
                  $error("filtered_speed: expected %0d, actual %0d",
                         want, rsp.filtered_speed);
                  fails++;
               end
            end
         end
      end
      pending_count <= expected_speeds.size();
      fail_count    <= fails;
   end

endmodule

### bench/testbench.sv
// Top of the speed moving-average filter bench: clock, reset, request and response
// stimulus with random stalls, default-window register phases, watchdog and verdict.
// Depends on smaf_pkg, smaf_req_if, smaf_rsp_if, filtered_speed_checker and the core.
module testbench import smaf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_SAMPLES   = 35;     // 8 phases -> about 400 beats in total
   localparam int SETTLE_CYCLES   = 4;      // pipeline slack before a register write
   localparam int DRAIN_CYCLES    = 8;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable;
   logic [WREQ_W-1:0] csr_write_data;
   int                pending_count;
   int                fail_count;
   int                quiet_cycles;

   // Idle-free stretches: each side flips its flag now and then.
   bit                req_no_idle;
   bit                rsp_no_idle;

   // Register values per phase; covers 0, the top legal value and the
   // saturating codes 5..7, so every data bit toggles.
   logic [WREQ_W-1:0] default_plan [8] = '{3'd4, 3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1, 3'd3};

   smaf_req_if req_bus ();
   smaf_rsp_if rsp_bus ();

   speed_moving_average_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   filtered_speed_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .fail_count       (fail_count)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Draws a speed value; the modes weight extremes, small values and the
   // neighborhood of full scale so the widened sum gets exercised.
   function automatic logic signed [SPEED_W-1:0] pick_speed(input int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
         2: return $signed($urandom_range(0, 200)) - 100;
         default: begin
            if ($urandom_range(0, 1)) begin
               return SPEED_MAX - $signed($urandom_range(0, 7));
            end
            return SPEED_MIN + $signed($urandom_range(0, 7));
         end
      endcase
   endfunction

   // One request beat. Valid is only lowered when a gap is drawn, so a
   // back-to-back beat never sees valid dropped and raised in one step.
   task automatic send_beat(input cmd_type cmd, input logic signed [SPEED_W-1:0] speed,
                            input logic [WREQ_W-1:0] wreq);
      int gap;
      if ($urandom_range(0, 23) == 0) begin
         req_no_idle = !req_no_idle;
      end
      gap = req_no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= cmd;
      req_bus.speed          <= speed;
      req_bus.window_request <= wreq;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Unused fields carry random bits so the block is seen to ignore them.
   task automatic send_sample(input logic signed [SPEED_W-1:0] speed);
      send_beat(CMD_SAMPLE, speed, WREQ_W'($urandom));
   endtask

   task automatic send_window(input logic [WREQ_W-1:0] wreq);
      send_beat(CMD_WINDOW, $urandom, wreq);
   endtask

   // Register write only with the block idle: all results back, then a settling
   // wait so a trailing window beat has left the input stage.
   task automatic write_default(input logic [WREQ_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Response side: fresh stall length per beat, ready held until a beat moves.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 23) == 0) begin
            rsp_no_idle = !rsp_no_idle;
         end
         gap = rsp_no_idle ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int samples;
      int burst_len;
      int burst_mode;
      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= CMD_SAMPLE;
      req_bus.speed          <= '0;
      req_bus.window_request <= '0;
      csr_write_enable       <= 1'b0;
      csr_write_data         <= '0;
      req_no_idle = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Pass-through out of reset: full-scale and sign extremes.
      send_sample(SPEED_MAX);
      send_sample(SPEED_MIN);
      send_sample(-32'sd1);
      send_sample(32'sd0);
      // Window of 4: ramp during first fill, then wrap with eviction.
      send_window(3'd2);
      repeat (5) send_sample(SPEED_MAX);
      repeat (5) send_sample(SPEED_MIN);
      // Same window again: state must be kept.
      send_window(3'd2);
      send_sample(32'sd7);
      // Out-of-range request with default 0 drops back to pass-through.
      send_window(3'd7);
      send_sample(-32'sd1);
      // Window of 2, negative rounding toward minus infinity.
      send_window(3'd1);
      send_sample(32'sd1);
      send_sample(-32'sd4);
      // Largest window, then back to pass-through by request 0.
      send_window(3'd4);
      send_sample(SPEED_MIN);
      send_window(3'd0);
      send_sample(32'sd5);

      // ---- random part, one default-register setting per phase ----
      foreach (default_plan[p]) begin
         write_default(default_plan[p]);
         samples = 0;
         while (samples < PHASE_SAMPLES) begin
            if ($urandom_range(0, 99) < 85) begin
               // Well-formed: pick a window, then a burst long enough to
               // wrap even the largest ring most of the time.
               send_window(WREQ_W'($urandom_range(0, 7)));
               burst_len  = $urandom_range(1, 40);
               burst_mode = $urandom_range(0, 3);
               repeat (burst_len) begin
                  if ($urandom_range(0, 4) == 0) begin
                     send_sample(pick_speed($urandom_range(0, 3)));
                  end else begin
                     send_sample(pick_speed(burst_mode));
                  end
               end
               samples += burst_len;
            end else if ($urandom_range(0, 1)) begin
               // Noise: stray window change in the middle of things.
               send_window(WREQ_W'($urandom));
            end else begin
               send_sample(pick_speed(0));
               samples++;
            end
         end
      end

      // ---- drain ----
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### speed_moving_average_filter_core.f
hdl/smaf_pkg.sv
hdl/smaf_req_if.sv
hdl/smaf_rsp_if.sv
hdl/smaf_ring.sv
hdl/smaf_accum.sv
hdl/speed_moving_average_filter_core.sv
bench/filtered_speed_checker.sv
bench/testbench.sv
